// ----- hdl/cps_pkg.sv -----
// Shared types and constants for the camera power sequencer.
// Holds the phase encoding, register indexes, load status codes and field widths.
// No dependencies.
package cps_pkg;

  // Field widths fixed by the pin interface
  localparam int CAM_W      = 2;
  localparam int CNT_W      = 24;
  localparam int WAIT_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Default number of fitted camera slots
  localparam int NUM_CAMERAS = 2;

  // Saturation value of the phase tick counter
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Sequencer phases, as shown on seq_phase
  typedef enum logic [3:0] {
    PH_INIT    = 4'd0,
    PH_ENABLE  = 4'd1,
    PH_WPOWER  = 4'd2,
    PH_WCLEAR  = 4'd3,
    PH_WCLOCK  = 4'd4,
    PH_STANDBY = 4'd5,
    PH_READY   = 4'd6,
    PH_DISABLE = 4'd7,
    PH_FAIL    = 4'd8
  } phase_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PGOOD_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_WAIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_WAIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STANDBY_WAIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_WINDOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_PRESENT   = 3'd5;

  // Register reset values
  localparam logic [CNT_W-1:0]  RST_PGOOD_TIMEOUT = 24'd150000;
  localparam logic [WAIT_W-1:0] RST_CLEAR_WAIT    = 16'd1;
  localparam logic [WAIT_W-1:0] RST_CLOCK_WAIT    = 16'd2;
  localparam logic [WAIT_W-1:0] RST_STANDBY_WAIT  = 16'd1000;
  localparam logic [WAIT_W-1:0] RST_WRITE_WINDOW  = 16'd14;
  localparam logic [CAM_W-1:0]  RST_CAM_PRESENT   = 2'd2;

  // Register load engine status codes
  localparam logic [1:0] LOAD_BUSY = 2'd0;
  localparam logic [1:0] LOAD_OK   = 2'd1;
  localparam logic [1:0] LOAD_FAIL = 2'd2;

endpackage

// ----- hdl/camera_power_sequencer.sv -----
// Top level of the camera power sequencer: phase state machine, wait counters,
// vsync write windows and the registered result stage.
// Depends on cps_pkg.

// Each input item is one 1 us timebase tick carrying the sampled power-good and
// vsync pins and the register-load engine status; each item yields exactly one
// result item showing pin drives and phase after that tick. The state machine and
// counters update at acceptance and the result lands in the output register on the
// same edge, so the result is visible in the cycle after the item is accepted.
// in_ready_o is high whenever the output register is empty or being taken, giving
// one item per cycle sustained while the result is taken each cycle. The
// configuration port is always ready; write it only while no tick is pending.
module camera_power_sequencer #(
  parameter int NUM_CAMERAS = cps_pkg::NUM_CAMERAS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // tick input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [cps_pkg::CAM_W-1:0]      power_good_i,
  input  logic [cps_pkg::CAM_W-1:0]      vsync_pin_i,
  input  logic [1:0]                     load_status_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [3:0]                     seq_phase_o,
  output logic [cps_pkg::CAM_W-1:0]      cam_enable_o,
  output logic [cps_pkg::CAM_W-1:0]      cam_clear_release_o,
  output logic [cps_pkg::CAM_W-1:0]      cam_trigger_o,
  output logic                           clock_out_enable_o,
  output logic                           load_request_o,
  output logic [cps_pkg::CAM_W-1:0]      load_mask_o,
  output logic [cps_pkg::CAM_W-1:0]      write_allowed_o,
  output logic                           failed_o
);

  localparam int CAM_W  = cps_pkg::CAM_W;
  localparam int CNT_W  = cps_pkg::CNT_W;
  localparam int WAIT_W = cps_pkg::WAIT_W;
  localparam logic [CAM_W-1:0] CAM_MASK = CAM_W'((1 << NUM_CAMERAS) - 1);

  // Configuration registers
  logic [CNT_W-1:0]  pgood_timeout_q;
  logic [WAIT_W-1:0] clear_wait_q;
  logic [WAIT_W-1:0] clock_wait_q;
  logic [WAIT_W-1:0] standby_wait_q;
  logic [WAIT_W-1:0] write_window_q;
  logic [CAM_W-1:0]  cam_present_q;

  // Sequencer state
  cps_pkg::phase_e   phase_q, phase_d;
  logic [CNT_W-1:0]  wait_q, wait_d;
  logic              enabled_q, enabled_d;
  logic [CAM_W-1:0]  good_q, good_d;
  logic [NUM_CAMERAS-1:0] prev_vs_q, prev_vs_d;
  logic [WAIT_W-1:0] win_q [NUM_CAMERAS];
  logic [WAIT_W-1:0] win_d [NUM_CAMERAS];
  logic [CAM_W-1:0]  enable_q, enable_d;
  logic [CAM_W-1:0]  clear_q, clear_d;
  logic [CAM_W-1:0]  trig_q, trig_d;
  logic              clk_oe_q, clk_oe_d;

  // Result register
  logic              out_valid_q;
  logic [3:0]        res_phase_q, res_phase_d;
  logic              res_load_req_q, res_load_req_d;
  logic [CAM_W-1:0]  res_allowed_q, res_allowed_d;
  logic              res_failed_q, res_failed_d;

  // Masked inputs and helpers
  logic [CAM_W-1:0]  pg;
  logic [CAM_W-1:0]  vs;
  logic [CAM_W-1:0]  present;
  logic [CNT_W-1:0]  wait_inc;
  logic              was_ready;
  logic              req_was_up;
  logic              in_fire;

  assign pg        = power_good_i & CAM_MASK;
  assign vs        = vsync_pin_i & CAM_MASK;
  assign present   = cam_present_q & CAM_MASK;
  assign wait_inc  = (wait_q == cps_pkg::CNT_MAX) ? wait_q : wait_q + 1'b1;
  assign was_ready = (phase_q == cps_pkg::PH_READY);
  assign req_was_up = (phase_q == cps_pkg::PH_STANDBY) &&
                      (wait_q >= CNT_W'(standby_wait_q));

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Take configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pgood_timeout_q <= cps_pkg::RST_PGOOD_TIMEOUT;
      clear_wait_q    <= cps_pkg::RST_CLEAR_WAIT;
      clock_wait_q    <= cps_pkg::RST_CLOCK_WAIT;
      standby_wait_q  <= cps_pkg::RST_STANDBY_WAIT;
      write_window_q  <= cps_pkg::RST_WRITE_WINDOW;
      cam_present_q   <= cps_pkg::RST_CAM_PRESENT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cps_pkg::REG_PGOOD_TIMEOUT: pgood_timeout_q <= cfg_data_i[CNT_W-1:0];
        cps_pkg::REG_CLEAR_WAIT:    clear_wait_q    <= cfg_data_i[WAIT_W-1:0];
        cps_pkg::REG_CLOCK_WAIT:    clock_wait_q    <= cfg_data_i[WAIT_W-1:0];
        cps_pkg::REG_STANDBY_WAIT:  standby_wait_q  <= cfg_data_i[WAIT_W-1:0];
        cps_pkg::REG_WRITE_WINDOW:  write_window_q  <= cfg_data_i[WAIT_W-1:0];
        cps_pkg::REG_CAM_PRESENT:   cam_present_q   <= cfg_data_i[CAM_W-1:0];
        default: ;
      endcase
    end
  end

  // Track vsync falls and run the per-camera write windows
  always_comb begin
    prev_vs_d     = prev_vs_q;
    res_allowed_d = '0;
    for (int i = 0; i < NUM_CAMERAS; i++) begin
      if (was_ready) begin
        prev_vs_d[i] = vs[i];
      end
      if (was_ready && !vs[i] && prev_vs_q[i]) begin
        win_d[i] = write_window_q;
      end else if (win_q[i] != '0) begin
        win_d[i] = win_q[i] - 1'b1;
      end else begin
        win_d[i] = win_q[i];
      end
      res_allowed_d[i] = was_ready && (win_d[i] != '0);
    end
  end

  // Next phase, wait counter and pin drives
  always_comb begin
    phase_d   = phase_q;
    wait_d    = wait_q;
    enabled_d = enabled_q;
    good_d    = good_q;
    enable_d  = enable_q;
    clear_d   = clear_q;
    trig_d    = trig_q;
    clk_oe_d  = clk_oe_q;
    case (phase_q)
      cps_pkg::PH_INIT: begin
        if (enabled_q) phase_d = cps_pkg::PH_ENABLE;
      end
      cps_pkg::PH_ENABLE: begin
        enable_d = CAM_MASK;
        phase_d  = cps_pkg::PH_WPOWER;
        wait_d   = '0;
      end
      cps_pkg::PH_WPOWER: begin
        good_d = pg;
        if ((present & ~pg) == '0) begin
          phase_d = cps_pkg::PH_WCLEAR;
          wait_d  = '0;
          trig_d  = CAM_MASK;
        end else begin
          wait_d = wait_inc;
          if (wait_inc > pgood_timeout_q) phase_d = cps_pkg::PH_FAIL;
        end
      end
      cps_pkg::PH_WCLEAR: begin
        wait_d = wait_inc;
        if (wait_inc > CNT_W'(clear_wait_q)) begin
          clear_d = CAM_MASK;
          phase_d = cps_pkg::PH_WCLOCK;
          wait_d  = '0;
        end
      end
      cps_pkg::PH_WCLOCK: begin
        wait_d = wait_inc;
        if (wait_inc > CNT_W'(clock_wait_q)) begin
          clk_oe_d = 1'b0;
          phase_d  = cps_pkg::PH_STANDBY;
          wait_d   = '0;
        end
      end
      cps_pkg::PH_STANDBY: begin
        // honor the load engine only once the request was already up
        if (req_was_up) begin
          if (good_q == '0 || load_status_i == cps_pkg::LOAD_OK) begin
            phase_d = cps_pkg::PH_READY;
          end else if (load_status_i == cps_pkg::LOAD_FAIL) begin
            phase_d = cps_pkg::PH_FAIL;
          end
        end else begin
          wait_d = wait_inc;
        end
      end
      cps_pkg::PH_READY: begin
        good_d = pg;
        if (!enabled_q || (present & ~pg) != '0) phase_d = cps_pkg::PH_DISABLE;
      end
      cps_pkg::PH_DISABLE: begin
        clear_d   = '0;
        trig_d    = '0;
        clk_oe_d  = 1'b1;
        enable_d  = '0;
        enabled_d = 1'b0;
        phase_d   = cps_pkg::PH_INIT;
      end
      default: begin
        // fail phase: hold everything shut down
        clear_d   = '0;
        trig_d    = '0;
        clk_oe_d  = 1'b1;
        enable_d  = '0;
        enabled_d = 1'b0;
        phase_d   = cps_pkg::PH_FAIL;
      end
    endcase
  end

  // Result fields derived from the post-tick state
  always_comb begin
    res_phase_d    = phase_d;
    res_failed_d   = (phase_d == cps_pkg::PH_FAIL);
    res_load_req_d = (phase_d == cps_pkg::PH_STANDBY) &&
                     (wait_d >= CNT_W'(standby_wait_q)) && (good_d != '0);
  end

  // Advance state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= cps_pkg::PH_INIT;
      wait_q    <= '0;
      enabled_q <= 1'b1;
      good_q    <= '0;
      prev_vs_q <= '0;
      enable_q  <= '0;
      clear_q   <= '0;
      trig_q    <= '0;
      clk_oe_q  <= 1'b1;
      for (int i = 0; i < NUM_CAMERAS; i++) begin
        win_q[i] <= '0;
      end
    end else if (in_fire) begin
      phase_q   <= phase_d;
      wait_q    <= wait_d;
      enabled_q <= enabled_d;
      good_q    <= good_d;
      prev_vs_q <= prev_vs_d;
      enable_q  <= enable_d;
      clear_q   <= clear_d;
      trig_q    <= trig_d;
      clk_oe_q  <= clk_oe_d;
      for (int i = 0; i < NUM_CAMERAS; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_phase_q    <= res_phase_d;
      res_load_req_q <= res_load_req_d;
      res_allowed_q  <= res_allowed_d;
      res_failed_q   <= res_failed_d;
    end
  end

  // Pin drives and mask come straight from the state, which moves with the result
  assign out_valid_o         = out_valid_q;
  assign seq_phase_o         = res_phase_q;
  assign cam_enable_o        = enable_q;
  assign cam_clear_release_o = clear_q;
  assign cam_trigger_o       = trig_q;
  assign clock_out_enable_o  = clk_oe_q;
  assign load_request_o      = res_load_req_q;
  assign load_mask_o         = good_q;
  assign write_allowed_o     = res_allowed_q;
  assign failed_o            = res_failed_q;

endmodule
